// ===== design/ccs_pkg.sv =====
// Package for the chunked CRC-32 / short-sum checksum block.
// Holds the item and result types, sizing constants and the per-byte update functions.
// No dependencies.
package ccs_pkg;

  localparam int CHUNK_BYTES = 512;
  localparam logic [31:0] CRC_POLY = 32'hEDB88320;

  localparam int CNT_W  = (CHUNK_BYTES > 1) ? $clog2(CHUNK_BYTES) : 1;
  localparam int SUM1_W = 17;
  localparam int SUM2_W = $clog2((CHUNK_BYTES + 1) * 65536);
  localparam int NDIG   = (SUM2_W + 7) / 8;

  typedef struct packed {
    logic       vld;
    logic [7:0] data;
    logic       last;
  } ccs_item_t;

  typedef struct packed {
    logic        vld;
    logic [31:0] value;
  } ccs_result_t;

  // One byte of reflected CRC-32.
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] v;
    v = {24'd0, crc[7:0] ^ b};
    for (int k = 0; k < 8; k++) begin
      v = v[0] ? ((v >> 1) ^ CRC_POLY) : (v >> 1);
    end
    return (crc >> 8) ^ v;
  endfunction

  // Remainder mod 255 by folding byte digits (256 == 1 mod 255).
  function automatic logic [7:0] mod255(input logic [SUM2_W-1:0] val);
    logic [8*NDIG-1:0] w;
    logic [9:0]        acc;
    logic [8:0]        f;
    w   = (8*NDIG)'(val);
    acc = '0;
    for (int i = 0; i < NDIG; i++) begin
      acc = acc + 10'(w[8*i +: 8]);
    end
    f = 9'(acc[7:0]) + 9'(acc[9:8]);
    if (f >= 9'd255) begin
      f = f - 9'd255;
    end
    return f[7:0];
  endfunction

endpackage

// ===== design/ccs_in_stage.sv =====
// Input register of the checksum block: holds one accepted item.
// Depends on ccs_pkg for the item type.
module ccs_in_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_data_byte,
  input  logic              in_last_byte,
  input  logic              take,
  output ccs_pkg::ccs_item_t item
);

  logic       vld_r, vld_nxt;
  logic [7:0] data_r;
  logic       last_r;

  assign in_ready = !vld_r || take;
  assign vld_nxt  = in_ready ? in_valid : vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= in_data_byte;
      last_r <= in_last_byte;
    end
  end

  assign item.vld  = vld_r;
  assign item.data = data_r;
  assign item.last = last_r;

endmodule

// ===== design/ccs_sum_core.sv =====
// Running CRC-32 and chunked short sum, updated once per item in one pass.
// Depends on ccs_pkg for types, sizes and the crc_byte / mod255 functions.
module ccs_sum_core (
  input  logic                clk,
  input  logic                rst_n,
  input  ccs_pkg::ccs_item_t  item,
  input  logic                out_free,
  input  logic                use_crc,
  output logic                take,
  output ccs_pkg::ccs_result_t res
);

  logic [ccs_pkg::SUM1_W-1:0] sum1_r, sum1_nxt;
  logic [ccs_pkg::SUM2_W-1:0] sum2_r, sum2_nxt;
  logic [31:0]                crc_r, crc_nxt;
  logic [ccs_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;

  logic [ccs_pkg::SUM1_W-1:0] s1_add, s1_new;
  logic [ccs_pkg::SUM2_W-1:0] s2_new;
  logic [31:0]                crc_new;
  logic [15:0]                short_res;
  logic                       chunk_end;

  assign take = item.vld && (!item.last || out_free);

  always_comb begin
    crc_new   = ccs_pkg::crc_byte(crc_r, item.data);
    s1_add    = sum1_r + ccs_pkg::SUM1_W'(item.data);
    s1_new    = (s1_add >= ccs_pkg::SUM1_W'(255)) ? s1_add - ccs_pkg::SUM1_W'(255) : s1_add;
    s2_new    = sum2_r + ccs_pkg::SUM2_W'(s1_new);
    // low byte of mod255 never carries into sum1's byte
    short_res = {s1_new[7:0], ccs_pkg::mod255(s2_new)};
    chunk_end = (cnt_r == ccs_pkg::CNT_W'(ccs_pkg::CHUNK_BYTES - 1));

    sum1_nxt = sum1_r;
    sum2_nxt = sum2_r;
    crc_nxt  = crc_r;
    cnt_nxt  = cnt_r;
    if (take) begin
      if (item.last) begin
        sum1_nxt = '0;
        sum2_nxt = '0;
        crc_nxt  = '0;
        cnt_nxt  = '0;
      end else if (chunk_end) begin
        sum1_nxt = ccs_pkg::SUM1_W'(short_res);
        sum2_nxt = ccs_pkg::SUM2_W'(short_res);
        crc_nxt  = crc_new;
        cnt_nxt  = '0;
      end else begin
        sum1_nxt = s1_new;
        sum2_nxt = s2_new;
        crc_nxt  = crc_new;
        cnt_nxt  = cnt_r + ccs_pkg::CNT_W'(1);
      end
    end

    res.vld   = take && item.last;
    res.value = use_crc ? crc_new : {16'd0, short_res};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum1_r <= '0;
      sum2_r <= '0;
      crc_r  <= '0;
      cnt_r  <= '0;
    end else begin
      sum1_r <= sum1_nxt;
      sum2_r <= sum2_nxt;
      crc_r  <= crc_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    take && item.last |=> cnt_r == '0 && crc_r == '0 && sum1_r == '0 && sum2_r == '0)
    else $error("sums not cleared after final item");

  a_reseed_equal: assert property (@(posedge clk) disable iff (!rst_n)
    take && !item.last && chunk_end |=>
      cnt_r == '0 && sum1_r == ccs_pkg::SUM1_W'(sum2_r))
    else $error("chunk restart seeds differ");

  a_sum1_range: assert property (@(posedge clk) disable iff (!rst_n)
    sum1_r <= ccs_pkg::SUM1_W'(65535))
    else $error("sum1 out of range");

endmodule

// ===== design/chunked_fletcher_or_crc32_checksum.sv =====
// Top level of the chunked CRC-32 / short-sum checksum block.
// Depends on ccs_pkg, ccs_in_stage and ccs_sum_core.
//
// Usage:
//   Bytes enter on in_valid/in_ready with in_data_byte and in_last_byte;
//   in_last_byte marks the final byte of a message. One checksum per message
//   leaves on out_valid/out_ready as out_checksum_value.
//   cfg_wr_en/cfg_wr_data write the mode bit: 1 gives the reflected CRC-32
//   (seed 0, no final xor), 0 gives the 16-bit chunked short sum in bits 15:0.
//   Write it only while no message is in flight.
// Timing:
//   One byte is taken every cycle while no final byte waits on a blocked result.
//   An item is held in the input register; the per-byte CRC and sum update is
//   done in one pass from there into the running sums and the result register,
//   which drives out_valid.
// Reset (rst_n low, synchronous): sums and counters clear, mode returns to CRC.
// Stall: while a result waits, bytes that are not final keep flowing; a final
//   byte waits in the input register and in_ready drops only then.
module chunked_fletcher_or_crc32_checksum (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_checksum_value
);

  ccs_pkg::ccs_item_t   item;
  ccs_pkg::ccs_result_t res;
  logic                 take;
  logic                 out_free;
  logic                 mode_r;
  logic                 out_vld_r, out_vld_nxt;
  logic [31:0]          out_val_r;

  ccs_in_stage u_in (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .take         (take),
    .item         (item)
  );

  ccs_sum_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .item     (item),
    .out_free (out_free),
    .use_crc  (mode_r),
    .take     (take),
    .res      (res)
  );

  assign out_free    = !out_vld_r || out_ready;
  assign out_vld_nxt = out_free ? res.vld : out_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= 1'b1;
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
      if (cfg_wr_en) begin
        mode_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && res.vld) begin
      out_val_r <= res.value;
    end
  end

  assign out_valid          = out_vld_r;
  assign out_checksum_value = out_val_r;

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without a blocked result");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_checksum_value))
    else $error("result changed while stalled");

  a_mode_write: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr_en |=> mode_r == $past(cfg_wr_data))
    else $error("mode write lost");

endmodule
